// File: rtl/core/adi_pkg.sv
// Shared types and constants of the audio DMA register core.
// No dependencies; every module of the core imports this package.
package adi_pkg;

    localparam int AddrW    = 24;
    localparam int CntW     = 30;
    localparam int RateW    = 26;
    localparam int DacW     = 14;
    localparam int CdW      = 48;
    localparam int ProdW    = 58;
    localparam int DivSteps = 58;
    localparam int StepW    = 6;

    localparam logic [1:0] OpRead  = 2'd0;
    localparam logic [1:0] OpWrite = 2'd1;
    localparam logic [1:0] OpTick  = 2'd2;

    localparam logic [31:0] AddrDram   = 32'h0450_0000;
    localparam logic [31:0] AddrLength = 32'h0450_0004;
    localparam logic [31:0] AddrEnable = 32'h0450_0008;
    localparam logic [31:0] AddrStatus = 32'h0450_000C;
    localparam logic [31:0] AddrRate   = 32'h0450_0010;

    localparam logic [RateW-1:0] DacClock    = 26'd48681812;
    localparam logic [27:0]      TicksPerSec = 28'd187500000;
    localparam logic [CdW-1:0]   CntMax      = {CdW{1'b1}};

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] bus_address;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0]      read_data;
        logic             irq_raise;
        logic             irq_clear;
        logic             dma_start;
        logic [AddrW-1:0] dma_address;
        logic [CntW-1:0]  dma_count;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_start;
        logic div_sel_prod;
        logic fin_cnt;
        logic fin_rate;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic start_div;
        logic rate_div;
        logic div_last;
    } t_dp_status;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_EXEC = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_DIVC = 8'b0000_1000,
        ST_FINC = 8'b0001_0000,
        ST_DIVR = 8'b0010_0000,
        ST_FINR = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

endpackage

// File: rtl/core/adi_div.sv
// Restoring divider of the audio DMA core, one quotient bit per cycle.
// Depends on adi_pkg for the operand widths and the step count.
module adi_div
    import adi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ProdW-1:0] i_dividend,
    input  logic [RateW-1:0] i_divisor,
    output logic             o_last,
    output logic [ProdW-1:0] o_quotient
);

    logic             r_run;
    logic [StepW-1:0] r_cnt;
    logic [RateW-1:0] r_rem;
    logic [RateW-1:0] r_divisor;
    logic [ProdW-1:0] r_quo;

    logic [RateW:0]   w_shift;
    logic [RateW:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[ProdW-1]};
    assign w_diff  = w_shift - {1'b0, r_divisor};
    assign w_ge    = w_shift >= {1'b0, r_divisor};

    assign o_last     = r_run && (r_cnt == StepW'(DivSteps - 1));
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + StepW'(1);
            if (o_last) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[RateW-1:0] : w_shift[RateW-1:0];
            r_quo <= {r_quo[ProdW-2:0], w_ge};
        end
    end

endmodule

// File: rtl/core/adi_dp.sv
// Datapath of the audio DMA core: register bank, second slot, countdown,
// product register, shared divider and output register. Uses adi_pkg, adi_div.
module adi_dp
    import adi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_out_data
);

    t_in_item         r_item;
    t_out_item        r_res;
    t_out_item        r_out;
    logic [ProdW-1:0] r_prod;

    logic [AddrW-1:0] r_dram;
    logic             r_en;
    logic [RateW-1:0] r_rate;
    logic             r_busy;
    logic             r_full;
    logic [AddrW-1:0] r_slot_addr;
    logic [CntW-1:0]  r_slot_cnt;
    logic [CdW-1:0]   r_cd;

    logic             w_is_write;
    logic             w_len_start;
    logic             w_tick_done;
    logic             w_start;
    logic [AddrW-1:0] w_start_addr;
    logic [CntW-1:0]  w_start_cnt;
    logic [CntW-1:0]  w_len_cnt;
    logic [DacW-1:0]  w_dac;
    logic [ProdW-1:0] w_dividend;
    logic [RateW-1:0] w_divisor;
    logic             w_div_last;
    logic [ProdW-1:0] w_quotient;

    assign w_is_write  = r_item.opcode == OpWrite;
    assign w_len_cnt   = {r_item.write_data[31:3], 1'b0};
    assign w_dac       = r_item.write_data[DacW-1:0];
    assign w_len_start = w_is_write && (r_item.bus_address == AddrLength) && r_en && !r_busy;
    assign w_tick_done = (r_item.opcode == OpTick) && r_busy && (r_cd <= CdW'(1));
    assign w_start     = w_len_start || (w_tick_done && r_full);
    assign w_start_addr = w_len_start ? r_dram : r_slot_addr;
    assign w_start_cnt  = w_len_start ? w_len_cnt : r_slot_cnt;

    assign o_status.start_div = w_start && (r_rate != '0);
    assign o_status.rate_div  = w_is_write && (r_item.bus_address == AddrRate) && (w_dac != '0);
    assign o_status.div_last  = w_div_last;

    assign w_dividend = i_cmd.div_sel_prod ? r_prod : {{(ProdW - RateW){1'b0}}, DacClock};
    assign w_divisor  = i_cmd.div_sel_prod ? r_rate : {{(RateW - DacW){1'b0}}, w_dac};

    adi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_last     (w_div_last),
        .o_quotient (w_quotient)
    );

    assign o_out_data = r_out;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_prod <= w_start_cnt * TicksPerSec;
            r_res  <= '0;
            if ((r_item.opcode == OpRead) && (r_item.bus_address == AddrStatus)) begin
                r_res.read_data <= {r_full, r_busy, 30'b0};
            end
            if (w_is_write && (r_item.bus_address == AddrStatus)) begin
                r_res.irq_clear <= 1'b1;
            end
            if (w_tick_done && r_full) begin
                r_res.irq_raise <= 1'b1;
            end
            if (w_start) begin
                r_res.dma_start   <= 1'b1;
                r_res.dma_address <= w_start_addr;
                r_res.dma_count   <= w_start_cnt;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dram      <= '0;
            r_en        <= 1'b0;
            r_rate      <= '0;
            r_busy      <= 1'b0;
            r_full      <= 1'b0;
            r_slot_addr <= '0;
            r_slot_cnt  <= '0;
            r_cd        <= '0;
        end else begin
            if (i_cmd.exec) begin
                case (r_item.opcode)
                    OpWrite: begin
                        case (r_item.bus_address)
                            AddrDram: begin
                                r_dram <= r_item.write_data[AddrW-1:0];
                            end
                            AddrLength: begin
                                if (r_en) begin
                                    if (r_busy) begin
                                        r_full      <= 1'b1;
                                        r_slot_addr <= r_dram;
                                        r_slot_cnt  <= w_len_cnt;
                                    end else begin
                                        r_busy <= 1'b1;
                                    end
                                end
                            end
                            AddrEnable: begin
                                r_en <= r_item.write_data[0];
                            end
                            default: ;
                        endcase
                    end
                    OpTick: begin
                        if (r_busy) begin
                            if (r_cd > CdW'(1)) begin
                                r_cd <= r_cd - CdW'(1);
                            end else begin
                                r_cd <= '0;
                                if (r_full) begin
                                    r_full <= 1'b0;
                                end else begin
                                    r_busy <= 1'b0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
                // Without a known frequency the countdown never expires in practice.
                if (w_start && (r_rate == '0)) begin
                    r_cd <= CntMax;
                end
            end
            if (i_cmd.fin_cnt) begin
                r_cd <= (|w_quotient[ProdW-1:CdW]) ? CntMax : w_quotient[CdW-1:0];
            end
            if (i_cmd.fin_rate) begin
                r_rate <= w_quotient[RateW-1:0];
            end
        end
    end

endmodule

// File: rtl/core/adi_ctrl.sv
// Controller of the audio DMA core: sequences decode, multiply, divide and
// result hand-off, and owns the output valid flag. Uses adi_pkg.
module adi_ctrl
    import adi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.start_div) begin
                    n_state = ST_MUL;
                end else if (i_status.rate_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIVR;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL: begin
                o_cmd.div_start    = 1'b1;
                o_cmd.div_sel_prod = 1'b1;
                n_state            = ST_DIVC;
            end
            ST_DIVC: begin
                if (i_status.div_last) begin
                    n_state = ST_FINC;
                end
            end
            ST_FINC: begin
                o_cmd.fin_cnt = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DIVR: begin
                if (i_status.div_last) begin
                    n_state = ST_FINR;
                end
            end
            ST_FINR: begin
                o_cmd.fin_rate = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/core/audio_dma_interface_regs_core.sv
// Audio DMA register core: one result transaction for every input transaction.
// Reads, plain writes and ticks go straight from decode to the output register;
// a nonzero DAC rate write and a set start at a known frequency first run the
// shared 58-step divider. Transactions are taken one at a time: a new one is
// accepted only after the previous result has moved into the output register.
// Reset (i_rst_n low at a clock edge) clears the register bank, flags, countdown,
// controller state and output valid.
module audio_dma_interface_regs_core
    import adi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // The controller steps each transaction through decode, an optional
    // multiply and divide, and the hand-off into the output register. The
    // output register lets a new input transaction be taken while the previous
    // result still waits for the consumer.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    adi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the register bank, the queued second set and the
    // completion countdown. Set starts load count times the tick rate into a
    // product register and divide it by the sample frequency; DAC rate writes
    // divide the DAC clock by the rate on the same divider.
    adi_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

endmodule

// File: bench/tb.sv
// Self-checking bench for audio_dma_interface_regs_core: register decode, double-buffered
// sample sets, the completion countdown, interrupts and valid/ready flow control.
// Depends on adi_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
    import adi_pkg::*;

    // Opcode 3 is reserved and must behave as a no-op with an all-zero result.
    localparam logic [1:0] OpNone = 2'd3;
    // Slowest sample frequency for which a set with a few samples still finishes
    // within a few hundred ticks (DAC rate 8).
    localparam logic [RateW-1:0] FastFreq = 26'd6085226;
    localparam int CycleLimit   = 1000000;
    localparam int SettleCycles = 70;
    localparam int TargetItems  = 1650;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    audio_dma_interface_regs_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the register bank, kept in step with every accepted
    // input transaction.
    // ------------------------------------------------------------------
    logic [AddrW-1:0] pm_dram_addr;
    logic             pm_enable;
    logic [RateW-1:0] pm_freq;
    logic             pm_busy;
    logic             pm_full;
    logic [AddrW-1:0] pm_slot_addr [2];
    logic [CntW-1:0]  pm_slot_cnt  [2];
    logic [CdW-1:0]   pm_countdown;

    // Results owed by the block, oldest first.
    t_out_item due_responses [$];

    int  items_sent      = 0;
    int  results_checked = 0;
    int  sets_started    = 0;
    int  irqs_raised     = 0;
    int  error_count     = 0;
    int  cycle_count     = 0;
    int  hold_request    = 0;
    bit  no_gaps         = 1'b0;

    // Starts the set in slot 0: reports it on the result and loads the
    // countdown with count * ticks-per-second / frequency, saturated to 48 bits.
    task automatic launch_set(inout t_out_item res);
        logic [63:0] prod;
        logic [63:0] quo;
        res.dma_start   = 1'b1;
        res.dma_address = pm_slot_addr[0];
        res.dma_count   = pm_slot_cnt[0];
        if (pm_freq == '0) begin
            pm_countdown = CntMax;
        end else begin
            prod = 64'(pm_slot_cnt[0]) * 64'(TicksPerSec);
            quo  = prod / 64'(pm_freq);
            pm_countdown = (quo > 64'(CntMax)) ? CntMax : quo[CdW-1:0];
        end
        sets_started++;
    endtask

    // Applies one bus access or tick to the shadow registers and queues the
    // result that the block owes for it.
    task automatic apply_bus_access(input t_in_item it);
        t_out_item       res;
        logic [CntW-1:0] cnt;
        logic [DacW-1:0] dac;
        res = '0;
        case (it.opcode)
            OpRead: begin
                if (it.bus_address == AddrStatus) begin
                    res.read_data = {pm_full, pm_busy, 30'd0};
                end
            end
            OpWrite: begin
                case (it.bus_address)
                    AddrDram: begin
                        pm_dram_addr = it.write_data[AddrW-1:0];
                    end
                    AddrLength: begin
                        // Length is in bytes, rounded down to whole sample pairs.
                        cnt = {it.write_data[31:3], 1'b0};
                        if (pm_enable && pm_busy) begin
                            pm_full         = 1'b1;
                            pm_slot_addr[1] = pm_dram_addr;
                            pm_slot_cnt[1]  = cnt;
                        end else if (pm_enable) begin
                            pm_busy         = 1'b1;
                            pm_slot_addr[0] = pm_dram_addr;
                            pm_slot_cnt[0]  = cnt;
                            launch_set(res);
                        end
                    end
                    AddrEnable: begin
                        pm_enable = it.write_data[0];
                    end
                    AddrStatus: begin
                        res.irq_clear = 1'b1;
                    end
                    AddrRate: begin
                        dac = it.write_data[DacW-1:0];
                        if (dac != '0) begin
                            pm_freq = DacClock / RateW'(dac);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OpTick: begin
                if (pm_busy && pm_countdown > 1) begin
                    pm_countdown = pm_countdown - 1'b1;
                end else if (pm_busy) begin
                    pm_countdown = '0;
                    if (pm_full) begin
                        // The queued set moves up and starts at once.
                        pm_full         = 1'b0;
                        pm_slot_addr[0] = pm_slot_addr[1];
                        pm_slot_cnt[0]  = pm_slot_cnt[1];
                        launch_set(res);
                        res.irq_raise = 1'b1;
                        irqs_raised++;
                    end else begin
                        pm_busy = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        due_responses.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Reporting and result checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40) begin
            $display("MISMATCH at result %0d: %s", results_checked, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
        end
    endtask

    // Every result transaction is checked against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_responses.size() == 0) begin
                report_mismatch("result transaction with nothing outstanding");
            end else begin
                want = due_responses.pop_front();
                compare_field("read_data", o_out_data.read_data, want.read_data);
                compare_field("irq_raise", 32'(o_out_data.irq_raise),
                              32'(want.irq_raise));
                compare_field("irq_clear", 32'(o_out_data.irq_clear),
                              32'(want.irq_clear));
                compare_field("dma_start", 32'(o_out_data.dma_start),
                              32'(want.dma_start));
                compare_field("dma_address", 32'(o_out_data.dma_address),
                              32'(want.dma_address));
                compare_field("dma_count", 32'(o_out_data.dma_count),
                              32'(want.dma_count));
            end
            results_checked++;
        end
    end

    // Result side: before each result transaction the receiver stalls for a
    // random number of cycles, or for the long hold-off when one is requested.
    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (hold_request != 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            @(negedge i_clk);
            if (stall != 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Run limit: far above the slowest legal run.
    initial begin : watchdog
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // Offers one input transaction after a random gap and returns at the edge
    // that accepts it. Valid is left high, so a following call with no gap
    // keeps it high and only swaps the payload at the next falling edge.
    task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                             input logic [31:0] data);
        t_in_item it;
        int       gap;
        it.opcode      = op;
        it.bus_address = addr;
        it.write_data  = data;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        apply_bus_access(it);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OpTick, $urandom(), $urandom());
    endtask

    task automatic tick_until_idle(input int limit);
        int n;
        n = 0;
        while (pm_busy && n < limit) begin
            send_tick();
            n++;
        end
    endtask

    // Sender pause: drops valid and waits until every owed result is back,
    // then lets the pipeline go quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (due_responses.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Length write whose sample count keeps the countdown short; at a slow
    // sample frequency only empty sets are queued.
    task automatic send_short_length();
        int k;
        k = (pm_freq >= FastFreq) ? $urandom_range(0, 3) : 0;
        send_item(OpWrite, AddrLength, 32'(k * 8 + $urandom_range(0, 7)));
    endtask

    // Reads, ticks, status acknowledges, DRAM and enable writes and accesses to
    // unknown addresses. Length and rate registers are left to the set sequences.
    task automatic send_noise();
        logic [31:0] addr;
        case ($urandom_range(0, 4))
            0: addr = $urandom();
            1: addr = AddrStatus;
            2: addr = AddrDram;
            3: addr = AddrEnable;
            default: addr = AddrRate + 32'($urandom_range(1, 3)) * 4;
        endcase
        send_item(2'($urandom_range(0, 3)), addr, $urandom());
    endtask

    // Reset values, address decode, the reserved opcode, ticks while idle,
    // a length write with DMA off and a zero DAC rate.
    task automatic test_decode_and_idle();
        send_item(OpRead,  AddrStatus,   32'h0000_0000);
        send_item(OpRead,  AddrDram,     32'hFFFF_FFFF);
        send_item(OpRead,  32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OpWrite, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OpNone,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OpNone,  32'h0000_0000, 32'h0000_0000);
        send_item(OpTick,  32'h0000_0000, 32'h0000_0000);
        send_item(OpWrite, AddrLength,   32'h0000_0010);
        send_item(OpWrite, AddrRate,     32'hFFFF_C000);
        send_item(OpRead,  AddrStatus,   32'hFFFF_FFFF);
    endtask

    // Double buffering at the fastest frequency: an empty set that expires on
    // its first tick, then a running set with the second slot filled and
    // overwritten, a status read and acknowledge, and the hand-over with its
    // interrupt.
    task automatic test_double_buffer();
        send_item(OpWrite, AddrRate,   32'h0000_0001);
        send_item(OpWrite, AddrDram,   32'hFF00_0000);
        send_item(OpWrite, AddrEnable, 32'h0000_0001);
        send_item(OpWrite, AddrLength, 32'h0000_0007);
        send_tick();
        send_item(OpWrite, AddrLength, 32'h0000_0008);
        send_item(OpWrite, AddrDram,   32'h00FF_FFFF);
        send_item(OpWrite, AddrLength, 32'h0000_0010);
        send_item(OpWrite, AddrLength, 32'h0000_0004);
        send_item(OpRead,  AddrStatus, 32'h0000_0000);
        send_item(OpWrite, AddrStatus, 32'hFFFF_FFFF);
        tick_until_idle(40);
        send_tick();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // back-to-back transactions, so the core backs up and drops in_ready.
    task automatic test_backpressure();
        int i;
        settle();
        hold_request = 400;
        no_gaps      = 1'b1;
        for (i = 0; i < 24; i++) begin
            case (i % 3)
                0: send_item(OpRead, AddrStatus, $urandom());
                1: send_tick();
                default: send_item(OpWrite, AddrDram, $urandom());
            endcase
        end
        no_gaps = 1'b0;
        settle();
    endtask

    // One randomized sample-set sequence: optional rate change, address and
    // enable set-up, one to three length writes, then mostly ticks until the
    // block is idle again, mixed with status traffic and noise.
    task automatic run_random_set();
        logic [DacW-1:0] dac;
        int              n_len;
        int              i;
        int              steps;
        if ($urandom_range(0, 2) == 0) begin
            // Slow rates only while idle, so every running set stays short.
            if (!pm_busy && $urandom_range(0, 4) == 0) begin
                dac = DacW'($urandom_range(0, 16383));
            end else begin
                dac = DacW'($urandom_range(1, 3));
            end
            send_item(OpWrite, AddrRate, ($urandom() & 32'hFFFF_C000) | 32'(dac));
        end
        send_item(OpWrite, AddrDram, $urandom());
        if ($urandom_range(0, 7) == 0) begin
            send_item(OpWrite, AddrEnable,
                      {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0});
            send_short_length();
        end
        if (!pm_enable || $urandom_range(0, 3) == 0) begin
            send_item(OpWrite, AddrEnable,
                      {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1});
        end
        n_len = $urandom_range(1, 3);
        for (i = 0; i < n_len; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_item(OpWrite, AddrDram, $urandom());
            end
            send_short_length();
        end
        steps = 0;
        while (pm_busy && steps < 400) begin
            case ($urandom_range(0, 19))
                0: send_item(OpRead, AddrStatus, $urandom());
                1: send_item(OpWrite, AddrStatus, $urandom());
                2: send_noise();
                3: send_short_length();
                default: send_tick();
            endcase
            steps++;
        end
        repeat ($urandom_range(0, 2)) send_tick();
    endtask

    task automatic test_random_traffic();
        while (items_sent < TargetItems) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) send_noise();
            end
            run_random_set();
        end
        no_gaps = 1'b0;
    endtask

    // Largest count at the slowest frequency, from the top DRAM address. Such a
    // set runs far longer than any simulation, so this comes last; the second
    // slot is filled behind it and a few ticks check the countdown keeps going.
    task automatic test_long_set();
        tick_until_idle(600);
        send_item(OpWrite, AddrRate,   32'hFFFF_FFFF);
        send_item(OpWrite, AddrDram,   32'hFFFF_FFFF);
        send_item(OpWrite, AddrEnable, 32'hFFFF_FFFF);
        send_item(OpWrite, AddrLength, 32'hFFFF_FFFF);
        send_item(OpWrite, AddrLength, 32'hFFFF_FFF8);
        send_item(OpRead,  AddrStatus, 32'hFFFF_FFFF);
        repeat (3) send_tick();
        send_item(OpWrite, AddrStatus, 32'hFFFF_FFFF);
        send_item(OpRead,  AddrStatus, 32'h0000_0000);
    endtask

    initial begin : main_sequence
        pm_dram_addr    = '0;
        pm_enable       = 1'b0;
        pm_freq         = '0;
        pm_busy         = 1'b0;
        pm_full         = 1'b0;
        pm_slot_addr[0] = '0;
        pm_slot_addr[1] = '0;
        pm_slot_cnt[0]  = '0;
        pm_slot_cnt[1]  = '0;
        pm_countdown    = '0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_decode_and_idle();
        test_double_buffer();
        test_backpressure();
        test_random_traffic();
        test_long_set();
        settle();

        $display("Covered %0d transactions: %0d set starts, %0d queued-set interrupts,",
                 items_sent, sets_started, irqs_raised);
        $display("long receiver hold-off, sender drain and random idling; %0d mismatches.",
                 error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
